// ===== hdl/htr_pkg.sv =====
package htr_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RpmW    = 26;

  // Microseconds per minute, the dividend of every rpm computation.
  localparam logic [RpmW-1:0] RpmNumerator = RpmW'(1000000 * 60);

  // One quotient bit per restoring step.
  localparam int unsigned DivSteps = RpmW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Request handed from the front to the back.
  typedef struct packed {
    logic             edge_res;
    logic [TimeW-1:0] period;
  } cmd_t;

endpackage

// ===== hdl/htr_front.sv =====
module htr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [htr_pkg::SampleW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [htr_pkg::SampleW-1:0]  sample_i,
  input  logic [htr_pkg::TimeW-1:0]    timestamp_i,
  input  logic                         full_i,
  output logic                         push_o,
  output htr_pkg::cmd_t                cmd_o
);
  import htr_pkg::*;

  logic [SampleW-1:0] thr_q;
  logic               prev_level_q;
  logic [TimeW-1:0]   last_edge_q;
  logic               level;
  logic               rise;

  assign level      = sample_i > thr_q;
  assign rise       = !prev_level_q && level;
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Wrapping subtraction gives the right period across a timer rollover.
  assign cmd_o.edge_res = rise;
  assign cmd_o.period   = timestamp_i - last_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= SampleW'(512);
      prev_level_q <= 1'b0;
      last_edge_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (push_o) begin
        prev_level_q <= level;
        if (rise) begin
          last_edge_q <= timestamp_i;
        end
      end
    end
  end

endmodule

// ===== hdl/htr_queue.sv =====
module htr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  htr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output htr_pkg::cmd_t data_o,
  output logic          empty_o
);
  import htr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/htr_back.sv =====
module htr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  htr_pkg::cmd_t             cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_edge_o,
  output logic [htr_pkg::RpmW-1:0]  out_rpm_o
);
  import htr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic [TimeW-1:0] divisor_q;
  logic [TimeW-1:0] rem_q;
  logic [RpmW-1:0]  quo_q;
  logic             edge_q;
  logic             out_valid_q;
  logic             out_edge_q;
  logic [RpmW-1:0]  out_rpm_q;

  logic [TimeW:0]   rem_sh;
  logic [TimeW:0]   rem_sub;
  logic             ge;

  // Restoring division: the dividend bits shift out of the quotient
  // register while the quotient bits shift in.
  assign rem_sh  = {rem_q, quo_q[RpmW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_q};
  assign ge      = rem_sh >= {1'b0, divisor_q};

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_edge_o  = out_edge_q;
  assign out_rpm_o   = out_rpm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      divisor_q   <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      edge_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_edge_q  <= 1'b0;
      out_rpm_q   <= '0;
    end else begin
      // The output register is refilled from ST_DONE; elsewhere a taken
      // result simply empties it.
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            edge_q    <= cmd_i.edge_res;
            divisor_q <= cmd_i.period;
            rem_q     <= '0;
            step_q    <= StepW'(DivSteps - 1);
            if (!cmd_i.edge_res) begin
              quo_q   <= '0;
              state_q <= ST_DONE;
            end else if (cmd_i.period == '0) begin
              // A zero period saturates to the numerator itself.
              quo_q   <= RpmNumerator;
              state_q <= ST_DONE;
            end else begin
              quo_q   <= RpmNumerator;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q <= ge ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
          quo_q <= {quo_q[RpmW-2:0], ge};
          if (step_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_edge_q  <= edge_q;
            out_rpm_q   <= quo_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/hall_tachometer_rpm_unit.sv =====
// Hall sensor tachometer. Each request carries a raw 10-bit hall sample and
// its free-running microsecond timestamp. The sample is compared against the
// level threshold (a sample strictly above it reads as high); on a rising
// edge of that level the block reports rpm = 60000000 / period, where the
// period is the wrapping 32-bit difference to the previous rising edge
// (measured from time 0 after reset), and the edge becomes the new
// reference. A zero period saturates rpm to 60000000. Samples without an
// edge return tuser = 0 and rpm = 0. Exactly one result leaves per request,
// in order. The front stage takes a request in any cycle in which the
// request queue has room, so a short burst is absorbed at once. The back
// stage drains the queue one request at a time: a rising edge with a
// nonzero period is loaded, runs 26 restoring divide steps for the 26-bit
// quotient and is then written to the output register; any other sample,
// a zero-period edge included, is loaded and then written to the output
// register. That write waits for as long as the output register still
// holds a result that has not been taken. A finished result waits in the
// output register while the next request is already being worked on. The
// threshold resets to 512 and may only be written while the block is idle.
module hall_tachometer_rpm_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Threshold register write.
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  // Sample requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [9:0] sample, [41:10] timestamp_us, [47:42] zero
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [25:0] rpm, [31:26] zero
  output logic        m_axis_tuser    // [0] edge_res
);
  import htr_pkg::*;

  cmd_t            push_cmd;
  cmd_t            pop_cmd;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  logic [RpmW-1:0] rpm;

  // Front: thresholding, edge detection and period measurement.
  htr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata[SampleW-1:0]),
    .timestamp_i (s_axis_tdata[SampleW+TimeW-1:SampleW]),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Short queue decoupling the front from the divider.
  htr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty)
  );

  // Back: iterative divider and output register.
  htr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_edge_o  (m_axis_tuser),
    .out_rpm_o   (rpm)
  );

  assign m_axis_tdata = {{(32 - RpmW){1'b0}}, rpm};

endmodule

// ===== hdl/htr_checker.sv =====
module htr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import htr_pkg::*;

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A sample without a rising edge reports zero rpm.
  a_no_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero rpm without an edge");

  // The quotient never exceeds the saturation value.
  a_rpm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 32'(RpmNumerator))
    else $error("rpm above saturation value");

endmodule

bind hall_tachometer_rpm_unit htr_checker u_htr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
